[hdl/sipu_pkg.sv]
// Types and constants for the segment intersection point unit.
// No dependencies; every other file imports this package.
package sipu_pkg;

  localparam int CW  = 32;          // coordinate width
  localparam int DW  = CW + 1;      // coordinate difference width
  localparam int PW  = 2 * DW;      // product width
  localparam int XW  = PW + 1;      // cross product width
  localparam int RW  = XW + 2;      // divider partial remainder width
  localparam int QW  = DW + 1;      // divider quotient width
  localparam int EW  = 40;          // epsilon register width
  localparam int DIV_STEPS = DW;

  localparam logic [EW-1:0] EPS_RESET = 40'd4294967;

  typedef enum logic [1:0] {
    OUT_CROSS      = 2'd0,
    OUT_COINCIDENT = 2'd1,
    OUT_PARALLEL   = 2'd2,
    OUT_OUTSIDE    = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [XW-1:0] mag;
    logic          neg;
  } cross_t;

  typedef struct packed {
    cross_t        dn;
    cross_t        na;
    cross_t        nb;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic [CW-1:0] x2;
    logic [CW-1:0] y2;
  } front_t;

  typedef struct packed {
    outcome_t      outcome;
    logic [XW-1:0] na;
    logic [XW-1:0] dn;
    logic [DW-1:0] mx;
    logic [DW-1:0] my;
    logic [XW-1:0] rx;
    logic [XW-1:0] ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          negx;
    logic          negy;
    logic [CW-1:0] p1x;
    logic [CW-1:0] p1y;
    logic [CW-1:0] midx;
    logic [CW-1:0] midy;
  } div_t;

endpackage

[hdl/sipu_cross.sv]
// Front end: coordinate differences, products and signed cross products.
// Four register stages; depends on sipu_pkg.
module sipu_cross import sipu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic signed [CW-1:0] x3,
  input  logic signed [CW-1:0] y3,
  input  logic signed [CW-1:0] x4,
  input  logic signed [CW-1:0] y4,
  output logic                 out_vld,
  output front_t               out_data
);

  logic [3:0] vld_r;
  logic signed [DW-1:0] dx12_r, dy12_r, dx34_r, dy34_r, dx13_r, dy13_r;
  logic [CW-1:0] c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;
  logic [CW-1:0] c4x_r, c4y_r, c5x_r, c5y_r, c6x_r, c6y_r;
  logic signed [PW-1:0] pd0_r, pd1_r, pa0_r, pa1_r, pb0_r, pb1_r;
  logic signed [XW-1:0] dn_r, na_r, nb_r;
  front_t out_r;

  function automatic cross_t to_mag(input logic signed [XW-1:0] v);
    cross_t c;
    c.neg = v[XW-1];
    c.mag = v[XW-1] ? -v : v;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx12_r <= DW'(x2) - DW'(x1);
      dy12_r <= DW'(y2) - DW'(y1);
      dx34_r <= DW'(x4) - DW'(x3);
      dy34_r <= DW'(y4) - DW'(y3);
      dx13_r <= DW'(x1) - DW'(x3);
      dy13_r <= DW'(y1) - DW'(y3);
      c1x_r  <= x1;
      c1y_r  <= y1;
      c2x_r  <= x2;
      c2y_r  <= y2;
      pd0_r  <= dy34_r * dx12_r;
      pd1_r  <= dx34_r * dy12_r;
      pa0_r  <= dx34_r * dy13_r;
      pa1_r  <= dy34_r * dx13_r;
      pb0_r  <= dx12_r * dy13_r;
      pb1_r  <= dy12_r * dx13_r;
      c3x_r  <= c1x_r;
      c3y_r  <= c1y_r;
      c4x_r  <= c2x_r;
      c4y_r  <= c2y_r;
      dn_r   <= XW'(pd0_r) - XW'(pd1_r);
      na_r   <= XW'(pa0_r) - XW'(pa1_r);
      nb_r   <= XW'(pb0_r) - XW'(pb1_r);
      c5x_r  <= c3x_r;
      c5y_r  <= c3y_r;
      c6x_r  <= c4x_r;
      c6y_r  <= c4y_r;
      out_r.dn <= to_mag(dn_r);
      out_r.na <= to_mag(na_r);
      out_r.nb <= to_mag(nb_r);
      out_r.x1 <= c5x_r;
      out_r.y1 <= c5y_r;
      out_r.x2 <= c6x_r;
      out_r.y2 <= c6y_r;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_data = out_r;

endmodule

[hdl/sipu_classify.sv]
// Classification against epsilon, midpoint and divider setup.
// One register stage; depends on sipu_pkg.
module sipu_classify import sipu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  front_t        in_data,
  input  logic [EW-1:0] eps,
  output logic          out_vld,
  output div_t          out_data
);

  logic vld_r;
  div_t out_r, out_nxt;
  logic bel_dn, bel_na, bel_nb, zero_dn, zero_na, zero_nb;
  logic out_a, out_b;
  logic signed [DW-1:0] dx, dy, sx, sy;

  always_comb begin
    bel_dn  = in_data.dn.mag < XW'(eps);
    bel_na  = in_data.na.mag < XW'(eps);
    bel_nb  = in_data.nb.mag < XW'(eps);
    zero_dn = in_data.dn.mag == '0;
    zero_na = in_data.na.mag == '0;
    zero_nb = in_data.nb.mag == '0;
    out_a   = (!zero_na && (in_data.na.neg != in_data.dn.neg)) ||
              (in_data.na.mag > in_data.dn.mag);
    out_b   = (!zero_nb && (in_data.nb.neg != in_data.dn.neg)) ||
              (in_data.nb.mag > in_data.dn.mag);
    dx = DW'($signed(in_data.x2)) - DW'($signed(in_data.x1));
    dy = DW'($signed(in_data.y2)) - DW'($signed(in_data.y1));
    sx = DW'($signed(in_data.x2)) + DW'($signed(in_data.x1));
    sy = DW'($signed(in_data.y2)) + DW'($signed(in_data.y1));

    out_nxt = '0;
    if (bel_dn && bel_na && bel_nb) begin
      out_nxt.outcome = OUT_COINCIDENT;
    end else if (bel_dn || zero_dn) begin
      out_nxt.outcome = OUT_PARALLEL;
    end else if (out_a || out_b) begin
      out_nxt.outcome = OUT_OUTSIDE;
    end else begin
      out_nxt.outcome = OUT_CROSS;
    end
    out_nxt.na   = in_data.na.mag;
    out_nxt.dn   = in_data.dn.mag;
    out_nxt.mx   = dx[DW-1] ? -dx : dx;
    out_nxt.my   = dy[DW-1] ? -dy : dy;
    out_nxt.negx = (in_data.na.neg ^ in_data.dn.neg) ^ dx[DW-1];
    out_nxt.negy = (in_data.na.neg ^ in_data.dn.neg) ^ dy[DW-1];
    out_nxt.p1x  = in_data.x1;
    out_nxt.p1y  = in_data.y1;
    out_nxt.midx = sx[DW-1:1];
    out_nxt.midy = sy[DW-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = out_r;

endmodule

[hdl/sipu_div_step.sv]
// One radix-2 step of the scaled quotient na*|d|/dn for both coordinates.
// One register stage; depends on sipu_pkg.
module sipu_div_step import sipu_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  div_t in_data,
  output logic out_vld,
  output div_t out_data
);

  logic vld_r;
  div_t out_r, out_nxt;

  function automatic logic [QW+XW-1:0] step(input logic [XW-1:0] r, input logic [QW-1:0] q,
                                            input logic [XW-1:0] na,
                                            input logic [XW-1:0] dn, input logic b);
    logic [RW-1:0] s, d1, d2;
    logic [XW-1:0] rn;
    logic [1:0]    dig;
    s  = {1'b0, r, 1'b0} + (b ? {2'b00, na} : '0);
    d1 = s - {2'b00, dn};
    d2 = s - {1'b0, dn, 1'b0};
    if (s >= {1'b0, dn, 1'b0}) begin
      rn  = d2[XW-1:0];
      dig = 2'd2;
    end else if (s >= {2'b00, dn}) begin
      rn  = d1[XW-1:0];
      dig = 2'd1;
    end else begin
      rn  = s[XW-1:0];
      dig = 2'd0;
    end
    return {{q[QW-2:0], 1'b0} + QW'(dig), rn};
  endfunction

  always_comb begin
    out_nxt = in_data;
    {out_nxt.qx, out_nxt.rx} = step(in_data.rx, in_data.qx, in_data.na, in_data.dn,
                                    in_data.mx[BIT]);
    {out_nxt.qy, out_nxt.ry} = step(in_data.ry, in_data.qy, in_data.na, in_data.dn,
                                    in_data.my[BIT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = out_r;

endmodule

[hdl/segment_intersection_point_unit.sv]
// Segment intersection point unit: top level.
// Depends on sipu_pkg, sipu_cross, sipu_classify and sipu_div_step.
//
// Usage:
//   Input channel in_*: one beat carries the endpoints of two segments,
//   signed Q16.16. Result channel out_*: one beat per input beat, in order,
//   with outcome, hit and the crossing (or coincident midpoint) coordinates.
//   cfg_we/cfg_data write the 40-bit epsilon threshold; write it only while
//   the pipeline is empty.
// Throughput: one beat per cycle unless stalled by out_stall; every
//   stage holds at most one beat. Pipeline: 4 cross product stages,
//   1 classify stage, 33 quotient steps and 1 output stage from input
//   beat to result beat.
// Reset: synchronous, active low; clears all valid bits and loads epsilon
//   with about 0.001 in Q8.32.
// Stall: while a result is held under out_stall, the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
module segment_intersection_point_unit import sipu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] in_first_start_x,
  input  logic signed [CW-1:0] in_first_start_y,
  input  logic signed [CW-1:0] in_first_end_x,
  input  logic signed [CW-1:0] in_first_end_y,
  input  logic signed [CW-1:0] in_second_start_x,
  input  logic signed [CW-1:0] in_second_start_y,
  input  logic signed [CW-1:0] in_second_end_x,
  input  logic signed [CW-1:0] in_second_end_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_outcome,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_cross_x,
  output logic signed [CW-1:0] out_cross_y,
  input  logic                 cfg_we,
  input  logic [EW-1:0]        cfg_data
);

  logic          en;
  logic [EW-1:0] eps_r;
  logic          fr_vld;
  front_t        fr_data;
  logic          vld [0:DIV_STEPS];
  div_t          stg [0:DIV_STEPS];
  logic          out_valid_r;
  logic [1:0]    out_outcome_r;
  logic          out_hit_r;
  logic [CW-1:0] out_x_r, out_y_r, x_nxt, y_nxt;
  div_t          last;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      eps_r <= cfg_data;
    end
  end

  sipu_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .x1       (in_first_start_x),
    .y1       (in_first_start_y),
    .x2       (in_first_end_x),
    .y2       (in_first_end_y),
    .x3       (in_second_start_x),
    .y3       (in_second_start_y),
    .x4       (in_second_end_x),
    .y4       (in_second_end_y),
    .out_vld  (fr_vld),
    .out_data (fr_data)
  );

  sipu_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_data  (fr_data),
    .eps      (eps_r),
    .out_vld  (vld[0]),
    .out_data (stg[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    sipu_div_step #(.BIT(DIV_STEPS - 1 - g)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[g]),
      .in_data  (stg[g]),
      .out_vld  (vld[g+1]),
      .out_data (stg[g+1])
    );
  end

  always_comb begin
    last  = stg[DIV_STEPS];
    x_nxt = '0;
    y_nxt = '0;
    case (last.outcome)
      OUT_CROSS: begin
        x_nxt = last.negx ? last.p1x - last.qx[CW-1:0] : last.p1x + last.qx[CW-1:0];
        y_nxt = last.negy ? last.p1y - last.qy[CW-1:0] : last.p1y + last.qy[CW-1:0];
      end
      OUT_COINCIDENT: begin
        x_nxt = last.midx;
        y_nxt = last.midy;
      end
      default: begin
        x_nxt = '0;
        y_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_outcome_r <= last.outcome;
      out_hit_r     <= (last.outcome == OUT_CROSS) || (last.outcome == OUT_COINCIDENT);
      out_x_r       <= x_nxt;
      out_y_r       <= y_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

endmodule
